@@ hdl/gfp_pkg.sv @@
package gfp_pkg;

	localparam int AlleleFieldW = 16;

	typedef enum logic [2:0] {
		PH_FIRST     = 3'd0,
		PH_AFTER_SEP = 3'd1,
		PH_DIGITS    = 3'd2,
		PH_DOT       = 3'd3,
		PH_SKIP      = 3'd4
	} phase_t;

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam logic [7:0] CH_BAR  = 8'h7C;
	localparam logic [7:0] CH_SL   = 8'h2F;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

endpackage

@@ hdl/genotype_field_parser_core.sv @@
// genotype field parser: takes genotype text one byte per beat on the char channel
// (char_valid, char_stall, char_code) and gives allele results on the res channel
// (res_valid, res_stall, allele, is_last, status). a zero byte ends a string.
// each allele is given when the byte that ends it arrives; the one that ends the
// string carries is_last, and an error result has status 1, is_last 1, allele 0.
// allow_bad_end is written through cfg_wr_en / cfg_wr_data; the user must write it
// only while the block is idle, which the block does not enforce. an accepted byte
// lands in the input register, is decoded there and any result is registered onto
// the res channel. throughput: one byte per cycle unless res_stall holds a result,
// set by the phase/accumulator update between the two registers (x10 add, saturate).
// when res_stall holds a waiting result, the byte in the input register waits too
// and char_stall rises; an empty input register always takes a new beat.
// reset (arst_n low) clears both registers' valid flags, returns the parser to the
// start of a string with a zero accumulator and clears allow_bad_end.
module genotype_field_parser_core
	import gfp_pkg::*;
#(
	parameter int ALLELE_BITS = 15
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic                           cfg_wr_data,
	input  logic                           char_valid,
	output logic                           char_stall,
	input  logic [7:0]                     char_code,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic signed [AlleleFieldW-1:0] allele,
	output logic                           is_last,
	output logic                           status
);

	localparam int AccW = ALLELE_BITS;
	localparam int MulW = ALLELE_BITS + 4;
	localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};

	logic                    allow_bad_end_q;
	logic                    char_valid_s1;
	logic [7:0]              char_s1;
	phase_t                  phase_q, phase_d;
	logic [AccW-1:0]         acc_q, acc_d;
	logic                    res_valid_q;
	logic [AlleleFieldW-1:0] allele_q;
	logic                    is_last_q;
	logic                    status_q;

	logic                    adv;
	logic                    proc;
	logic                    is_dig;
	logic                    is_sep;
	logic [MulW-1:0]         mul_sum;
	logic [AccW+AlleleFieldW-1:0] acc_ext;
	logic [AlleleFieldW-1:0] acc_field;
	logic                    emit;
	logic [AlleleFieldW-1:0] e_allele;
	logic                    e_last;
	logic                    e_status;

	assign adv        = !res_valid_q || !res_stall;
	assign proc       = char_valid_s1 && adv;
	assign char_stall = char_valid_s1 && !adv;

	assign is_dig  = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
	assign is_sep  = (char_s1 == CH_BAR) || (char_s1 == CH_SL);
	// acc*10 as two shifts, plus the digit (low nibble of '0'..'9')
	assign mul_sum = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
		+ {{(MulW-4){1'b0}}, char_s1[3:0]};
	assign acc_ext   = {{AlleleFieldW{1'b0}}, acc_q};
	assign acc_field = acc_ext[AlleleFieldW-1:0];

	always_comb begin
		phase_d  = phase_q;
		acc_d    = acc_q;
		emit     = 1'b0;
		e_allele = '0;
		e_last   = 1'b0;
		e_status = 1'b0;
		unique case (phase_q) inside
			PH_SKIP: begin
				if (char_s1 == CH_NUL) phase_d = PH_FIRST;
			end
			PH_DIGITS, PH_DOT: begin
				if (phase_q == PH_DIGITS && is_dig) begin
					acc_d = (mul_sum > {{(MulW-AccW){1'b0}}, AccMax}) ? AccMax
						: mul_sum[AccW-1:0];
				end else begin
					// a complete allele ended by this byte
					acc_d    = '0;
					emit     = 1'b1;
					e_allele = (phase_q == PH_DOT) ? {AlleleFieldW{1'b1}} : acc_field;
					if (char_s1 == CH_NUL) begin
						phase_d = PH_FIRST;
						e_last  = 1'b1;
					end else if (is_sep) begin
						phase_d = PH_AFTER_SEP;
					end else begin
						phase_d = PH_SKIP;
						e_last  = 1'b1;
						if (!allow_bad_end_q) begin
							e_allele = '0;
							e_status = 1'b1;
						end
					end
				end
			end
			default: begin
				// start of an allele, stray codes included
				acc_d = '0;
				if (is_dig) begin
					acc_d   = {{(AccW-4){1'b0}}, char_s1[3:0]};
					phase_d = PH_DIGITS;
				end else if (char_s1 == CH_DOT) begin
					phase_d = PH_DOT;
				end else begin
					phase_d  = (char_s1 == CH_NUL) ? PH_FIRST : PH_SKIP;
					emit     = 1'b1;
					e_last   = 1'b1;
					e_status = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_bad_end_q <= 1'b0;
		end else if (cfg_wr_en) begin
			allow_bad_end_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			char_valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!char_stall && char_valid) char_s1 <= char_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			acc_q   <= '0;
		end else if (proc) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= proc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			allele_q  <= e_allele;
			is_last_q <= e_last;
			status_q  <= e_status;
		end
	end

	assign res_valid = res_valid_q;
	assign allele    = allele_q;
	assign is_last   = is_last_q;
	assign status    = status_q;

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && status_q |-> is_last_q && allele_q == '0)
		else $error("error beat without is_last or with nonzero allele");

	a_acc_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_DIGITS |-> acc_q == '0)
		else $error("accumulator not cleared outside digit phase");

	a_skip_silent: assert property (@(posedge clk) disable iff (!arst_n)
		proc && phase_q == PH_SKIP |=> !res_valid_q)
		else $error("result produced while skipping");

	a_stall_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid_s1 && !adv |=> char_valid_s1 && $stable(phase_q) && $stable(acc_q))
		else $error("parser state moved while output held");

endmodule
